/* src/mrfr_pkg.sv */
// Shared types and constants for the Modbus RTU frame recognizer.
// Holds the status codes, the result item and the pipeline control struct.
// No dependencies.
`default_nettype none

package mrfr_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned IndexW = 9;
	localparam int unsigned CrcW   = 16;

	// Status reported with every echoed byte.
	typedef enum logic [1:0] {
		STAT_INSIDE  = 2'd0,
		STAT_GOOD    = 2'd1,
		STAT_BADCRC  = 2'd2,
		STAT_DISCARD = 2'd3
	} frame_status_t;

	// One result item.
	typedef struct packed {
		logic [ByteW-1:0]  out_byte;
		logic [IndexW-1:0] frame_index;
		logic              frame_last;
		frame_status_t     frame_status;
	} result_t;

	// Pipeline control shared by the stages.
	typedef struct packed {
		logic advance; // the result register can take a new item
		logic fire;    // the input register hands its byte to the parser
	} stage_ctl_t;

endpackage

`default_nettype wire

/* src/modbus_rtu_frame_recognizer_core.sv */
// Top level of the Modbus RTU frame recognizer.
// Instantiates mrfr_in_stage, mrfr_parser and mrfr_out_stage; uses mrfr_pkg.
`default_nettype none

// The recognizer takes a received serial stream one byte per transfer and
// echoes every byte with its position in the current frame, an end-of-frame
// mark on tlast and a status on tuser: inside a frame, frame good, CRC
// mismatch, or byte discarded. A frame opens with a byte equal to the
// station address register and then a function code; codes 3 and 4 take
// their length from the byte-count field (count plus five bytes), codes 6
// and 16 are eight bytes long, and any other code is discarded and the
// block goes back to hunting for an address. The Modbus CRC-16 runs over the
// whole frame, and the last byte reports good when the residue is zero.
// The block sustains one byte per clock cycle while the output is taken. A
// byte is held in the input register and then moves into the result register,
// from which its result is offered on the output; the bytewise CRC update in
// the parser between the two registers is the path that limits the clock. The
// two registers stall together when the output is not taken: a new byte is
// still accepted while a result waits on the output as long as the input
// register is empty, and once both hold a byte the input stays not ready until
// the output transfer happens. The station address is written through the cfg
// channel, which is always ready and should only be written while no bytes
// are in flight.

module modbus_rtu_frame_recognizer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write channel: station address.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data,
	// Input stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] rx_byte
	// Output stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // [7:0] out_byte, [16:8] frame_index, [23:17] zero
	output logic             m_tlast,  // frame_last
	output logic [1:0]       m_tuser   // [1:0] frame_status
);
	import mrfr_pkg::*;

	logic [ByteW-1:0] station_address_q;
	logic [ByteW-1:0] rx_byte_s1;
	logic             advance;
	stage_ctl_t       ctl;
	result_t          res;
	result_t          res_s2;

	// The address register takes every transfer on the cfg channel.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_address_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			station_address_q <= cfg_data;
		end
	end

	mrfr_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.advance    (advance),
		.ctl        (ctl),
		.rx_byte_s1 (rx_byte_s1)
	);

	mrfr_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.station_address (station_address_q),
		.ctl             (ctl),
		.rx_byte_s1      (rx_byte_s1),
		.res             (res)
	);

	mrfr_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.res      (res),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.advance  (advance),
		.res_s2   (res_s2)
	);

	assign m_tdata = {7'd0, res_s2.frame_index, res_s2.out_byte};
	assign m_tlast = res_s2.frame_last;
	assign m_tuser = res_s2.frame_status;

endmodule

`default_nettype wire

/* src/mrfr_in_stage.sv */
// Input register of the frame recognizer: holds one received byte.
// Depends on mrfr_pkg for the stage control struct.
`default_nettype none

module mrfr_in_stage (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [7:0]               s_tdata,
	input  wire logic                     advance,
	output mrfr_pkg::stage_ctl_t          ctl,
	output logic [mrfr_pkg::ByteW-1:0]    rx_byte_s1
);
	import mrfr_pkg::*;

	logic valid_s1;

	assign ctl.advance = advance;
	assign ctl.fire    = valid_s1 && advance;
	assign s_tready    = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rx_byte_s1 <= s_tdata[ByteW-1:0];
		end
	end

endmodule

`default_nettype wire

/* src/mrfr_parser.sv */
// Frame parser: phase machine, byte counter and bytewise Modbus CRC-16.
// Builds the result for the byte in the input register; depends on mrfr_pkg.
`default_nettype none

module mrfr_parser (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [7:0]               station_address,
	input  wire mrfr_pkg::stage_ctl_t     ctl,
	input  wire logic [mrfr_pkg::ByteW-1:0] rx_byte_s1,
	output mrfr_pkg::result_t             res
);
	import mrfr_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_FUNC  = 2'd1,
		PH_COUNT = 2'd2,
		PH_BODY  = 2'd3
	} phase_t;

	localparam logic [CrcW-1:0]   CrcInit  = 16'hFFFF;
	localparam logic [CrcW-1:0]   CrcPoly  = 16'hA001;
	localparam logic [ByteW-1:0]  FcReadHold  = 8'd3;
	localparam logic [ByteW-1:0]  FcReadInput = 8'd4;
	localparam logic [ByteW-1:0]  FcWriteOne  = 8'd6;
	localparam logic [ByteW-1:0]  FcWriteMany = 8'd16;
	localparam logic [IndexW-1:0] FixedLen    = 9'd8;
	localparam logic [IndexW-1:0] LenOverhead = 9'd5;

	function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] crc_in,
	                                             input logic [ByteW-1:0] b);
		logic [CrcW-1:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) c = (c >> 1) ^ CrcPoly;
			else      c = c >> 1;
		end
		return c;
	endfunction

	phase_t            phase_q, phase_d;
	logic [IndexW-1:0] count_q, count_d;
	logic [IndexW-1:0] exp_len_q, exp_len_d;
	logic [CrcW-1:0]   crc_q, crc_d;
	logic [CrcW-1:0]   crc_next;
	logic [IndexW-1:0] count_inc;

	assign crc_next  = crc_feed((phase_q == PH_HUNT) ? CrcInit : crc_q, rx_byte_s1);
	assign count_inc = count_q + 9'd1;

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		exp_len_d = exp_len_q;
		crc_d     = crc_q;
		res.out_byte     = rx_byte_s1;
		res.frame_index  = '0;
		res.frame_last   = 1'b0;
		res.frame_status = STAT_INSIDE;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte_s1 == station_address) begin
					crc_d   = crc_next;
					count_d = 9'd1;
					phase_d = PH_FUNC;
				end else begin
					res.frame_status = STAT_DISCARD;
				end
			end
			PH_FUNC: begin
				res.frame_index = 9'd1;
				if (rx_byte_s1 == FcReadHold || rx_byte_s1 == FcReadInput) begin
					crc_d   = crc_next;
					count_d = 9'd2;
					phase_d = PH_COUNT;
				end else if (rx_byte_s1 == FcWriteOne || rx_byte_s1 == FcWriteMany) begin
					crc_d     = crc_next;
					count_d   = 9'd2;
					exp_len_d = FixedLen;
					phase_d   = PH_BODY;
				end else begin
					// Unsupported function code: drop the frame, back to hunting.
					res.frame_status = STAT_DISCARD;
					phase_d   = PH_HUNT;
					count_d   = '0;
					exp_len_d = '0;
					crc_d     = CrcInit;
				end
			end
			PH_COUNT: begin
				res.frame_index = 9'd2;
				crc_d     = crc_next;
				exp_len_d = LenOverhead + {1'b0, rx_byte_s1};
				count_d   = 9'd3;
				phase_d   = PH_BODY;
			end
			PH_BODY: begin
				res.frame_index = count_q;
				crc_d   = crc_next;
				count_d = count_inc;
				if (count_inc >= exp_len_q) begin
					// The residue over data plus received CRC is zero on a good frame.
					res.frame_last   = 1'b1;
					res.frame_status = (crc_next == '0) ? STAT_GOOD : STAT_BADCRC;
					phase_d   = PH_HUNT;
					count_d   = '0;
					exp_len_d = '0;
					crc_d     = CrcInit;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			count_q   <= '0;
			exp_len_q <= '0;
			crc_q     <= CrcInit;
		end else if (ctl.fire) begin
			phase_q   <= phase_d;
			count_q   <= count_d;
			exp_len_q <= exp_len_d;
			crc_q     <= crc_d;
		end
	end

endmodule

`default_nettype wire

/* src/mrfr_out_stage.sv */
// Result register of the frame recognizer, driving the master-side stream.
// Depends on mrfr_pkg for the result item and the stage control struct.
`default_nettype none

module mrfr_out_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mrfr_pkg::stage_ctl_t ctl,
	input  wire mrfr_pkg::result_t    res,
	input  wire logic                 m_tready,
	output logic                      m_tvalid,
	output logic                      advance,
	output mrfr_pkg::result_t         res_s2
);
	import mrfr_pkg::*;

	logic valid_s2;

	assign m_tvalid = valid_s2;
	assign advance  = !valid_s2 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ctl.advance) begin
			valid_s2 <= ctl.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			res_s2 <= res;
		end
	end

endmodule

`default_nettype wire

/* bench/mrfr_bench_pkg.sv */
`timescale 1ns / 1ps
// Constants and the CRC helper shared by the frame recognizer bench files.
// Used by the stimulus in the bench top and by the frame checker; no dependencies.

package mrfr_bench_pkg;

	// Modbus function codes that the recognizer accepts.
	localparam logic [7:0] FC_READ_HOLDING    = 8'd3;
	localparam logic [7:0] FC_READ_INPUT      = 8'd4;
	localparam logic [7:0] FC_WRITE_SINGLE    = 8'd6;
	localparam logic [7:0] FC_WRITE_MULTIPLE  = 8'd16;

	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'hA001;

	// One byte of the reflected Modbus CRC-16.
	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

	function automatic bit code_supported(input logic [7:0] b);
		return b == FC_READ_HOLDING || b == FC_READ_INPUT ||
			b == FC_WRITE_SINGLE || b == FC_WRITE_MULTIPLE;
	endfunction

endpackage

/* bench/mrfr_frame_checker.sv */
`timescale 1ns / 1ps
// Frame checker: tracks the station address and the frame parse of the recognizer,
// predicts each echoed byte and compares it with the output stream.
// Depends on mrfr_pkg and mrfr_bench_pkg.

module mrfr_frame_checker
	import mrfr_pkg::*;
	import mrfr_bench_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [23:0] m_tdata,
	input  wire logic        m_tlast,
	input  wire logic [1:0]  m_tuser,
	output int               fail_count,
	output int               pending,
	output int               good_frames,
	output int               crc_errors,
	output int               discards
);

	typedef enum logic [1:0] {
		SEEK_ADDR  = 2'd0,
		TAKE_CODE  = 2'd1,
		TAKE_COUNT = 2'd2,
		TAKE_BODY  = 2'd3
	} parse_phase_t;

	localparam int MaxReports = 20;

	logic [7:0]   station;
	parse_phase_t phase;
	logic [8:0]   taken;
	logic [8:0]   frame_len;
	logic [15:0]  crc;
	result_t      expected_echo[$];

	initial begin
		fail_count  = 0;
		pending     = 0;
		good_frames = 0;
		crc_errors  = 0;
		discards    = 0;
	end

	task automatic restart_hunt();
		phase     = SEEK_ADDR;
		taken     = 9'd0;
		frame_len = 9'd0;
		crc       = CrcInit;
	endtask

	task automatic predict_echo(input logic [7:0] b);
		result_t r;
		r.out_byte     = b;
		r.frame_index  = 9'd0;
		r.frame_last   = 1'b0;
		r.frame_status = STAT_INSIDE;
		case (phase)
			SEEK_ADDR: begin
				if (b == station) begin
					crc   = crc_add(CrcInit, b);
					taken = 9'd1;
					phase = TAKE_CODE;
				end else begin
					r.frame_status = STAT_DISCARD;
				end
			end
			TAKE_CODE: begin
				r.frame_index = 9'd1;
				if (b == FC_READ_HOLDING || b == FC_READ_INPUT) begin
					crc   = crc_add(crc, b);
					taken = 9'd2;
					phase = TAKE_COUNT;
				end else if (b == FC_WRITE_SINGLE || b == FC_WRITE_MULTIPLE) begin
					crc       = crc_add(crc, b);
					taken     = 9'd2;
					frame_len = 9'd8;
					phase     = TAKE_BODY;
				end else begin
					// The rejected code byte is not retried as an address.
					r.frame_status = STAT_DISCARD;
					restart_hunt();
				end
			end
			TAKE_COUNT: begin
				r.frame_index = 9'd2;
				crc       = crc_add(crc, b);
				frame_len = 9'd5 + {1'b0, b};
				taken     = 9'd3;
				phase     = TAKE_BODY;
			end
			default: begin
				r.frame_index = taken;
				crc   = crc_add(crc, b);
				taken = taken + 9'd1;
				if (taken >= frame_len) begin
					r.frame_last   = 1'b1;
					r.frame_status = (crc == 16'h0000) ? STAT_GOOD : STAT_BADCRC;
					restart_hunt();
				end
			end
		endcase
		case (r.frame_status)
			STAT_GOOD:    good_frames++;
			STAT_BADCRC:  crc_errors++;
			STAT_DISCARD: discards++;
			default:      ;
		endcase
		expected_echo = {expected_echo, r};
	endtask

	task automatic report(input string what, input int want, input int got);
		fail_count++;
		if (fail_count <= MaxReports)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
	endtask

	task automatic check_echo(input result_t got);
		result_t want;
		if (expected_echo.size() == 0) begin
			fail_count++;
			if (fail_count <= MaxReports)
				$display("%0t: expected no transfer, got byte %0d index %0d", $time,
					got.out_byte, got.frame_index);
			return;
		end
		want = expected_echo.pop_front();
		if (got.out_byte != want.out_byte)
			report("out_byte", want.out_byte, got.out_byte);
		if (got.frame_index != want.frame_index)
			report("frame_index", want.frame_index, got.frame_index);
		if (got.frame_last != want.frame_last)
			report("frame_last", want.frame_last, got.frame_last);
		if (got.frame_status != want.frame_status)
			report("frame_status", want.frame_status, got.frame_status);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station = 8'h00;
			restart_hunt();
			expected_echo.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				station = cfg_data;
			if (s_tvalid && s_tready)
				predict_echo(s_tdata);
			if (m_tvalid && m_tready)
				check_echo({m_tdata[7:0], m_tdata[16:8], m_tlast, m_tuser});
			pending = expected_echo.size();
		end
	end

endmodule

/* bench/modbus_rtu_frame_recognizer_core_tb.sv */
`timescale 1ns / 1ps
// Bench top for modbus_rtu_frame_recognizer_core: clock, reset, stimulus and verdict.
// Instantiates the core and mrfr_frame_checker; uses mrfr_pkg and mrfr_bench_pkg.

module modbus_rtu_frame_recognizer_core_tb;
	import mrfr_pkg::*;
	import mrfr_bench_pkg::*;

	// The watchdog bound is far above the slowest legal run: roughly 1000 bytes, each
	// with a sender gap and a stalled receiver, plus a few long output holds.
	localparam int LimitCycles  = 400000;
	localparam int HoldCycles   = 300;
	localparam int PhaseBytes   = 140;
	localparam int DrainCycles  = 8;

	typedef enum int {
		RX_FREE,
		RX_MOSTLY,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'h00;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;           // [7:0] out_byte, [16:8] frame_index, [23:17] zero
	logic        m_tlast;           // frame_last
	logic [1:0]  m_tuser;           // [1:0] frame_status

	int fail_count;
	int pending;
	int good_frames;
	int crc_errors;
	int discards;

	// Stimulus bookkeeping.
	logic [7:0] cur_addr = 8'h00;
	int         sent = 0;
	int         burst_left = 0;
	int         addr_writes = 0;
	int         holds = 0;
	int         cycles = 0;
	bit         hold_req = 1'b0;

	modbus_rtu_frame_recognizer_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	mrfr_frame_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.fail_count  (fail_count),
		.pending     (pending),
		.good_frames (good_frames),
		.crc_errors  (crc_errors),
		.discards    (discards)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offers one byte and returns at the falling edge after its transfer. The sender
	// runs in bursts; tvalid stays high across a burst and drops only for a gap.
	task automatic emit(input logic [7:0] b);
		int gap;
		s_tdata  <= b;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// Builds a frame for the current station address and sends it. A corrupted frame
	// has one bit flipped after the header, so its length stays intact; a cut frame
	// stops early and the bytes that follow are taken as its body.
	task automatic send_frame(input logic [7:0] fcode, input int count, input bit corrupt,
			input bit cut);
		logic [7:0]  fb [0:259];
		logic [15:0] crc;
		logic [7:0]  d;
		int          n;
		int          body;
		int          hdr;
		int          pos;
		fb[0] = cur_addr;
		fb[1] = fcode;
		crc = crc_add(crc_add(CrcInit, cur_addr), fcode);
		n = 2;
		if (fcode == FC_READ_HOLDING || fcode == FC_READ_INPUT) begin
			fb[2] = count[7:0];
			crc = crc_add(crc, count[7:0]);
			n = 3;
			body = count;
		end else begin
			body = 4;
		end
		hdr = n;
		repeat (body) begin
			d = 8'($urandom_range(0, 255));
			fb[n] = d;
			crc = crc_add(crc, d);
			n++;
		end
		// CRC goes out low byte first.
		fb[n] = crc[7:0];
		fb[n + 1] = crc[15:8];
		n = n + 2;
		if (corrupt) begin
			pos = $urandom_range(hdr, n - 1);
			fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(0, 7));
		end
		if (cut)
			n = $urandom_range(1, n - 1);
		for (int i = 0; i < n; i++)
			emit(fb[i]);
	endtask

	function automatic logic [7:0] pick_code();
		case ($urandom_range(0, 3))
			0:       return FC_READ_HOLDING;
			1:       return FC_READ_INPUT;
			2:       return FC_WRITE_SINGLE;
			default: return FC_WRITE_MULTIPLE;
		endcase
	endfunction

	function automatic logic [7:0] pick_bad_code();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		while (code_supported(b))
			b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	// Mostly short frames; now and then the longest one, with a byte count of 255.
	function automatic int pick_count();
		return ($urandom_range(0, 39) == 0) ? 255 : $urandom_range(0, 16);
	endfunction

	// The station address only changes while nothing is in flight, so the input is
	// parked and the output drained first.
	task automatic write_station(input logic [7:0] a);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
		cfg_data  <= a;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_addr = a;
		addr_writes++;
	endtask

	// One random phase: mostly well-formed frames with random content, the rest
	// corrupted or cut frames, line noise, rejected function codes and lone addresses.
	task automatic run_phase();
		int start;
		int r;
		start = sent;
		while (sent - start < PhaseBytes) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				send_frame(pick_code(), pick_count(), 1'b0, 1'b0);
			end else if (r < 72) begin
				send_frame(pick_code(), pick_count(), 1'b1, 1'b0);
			end else if (r < 80) begin
				send_frame(pick_code(), pick_count(), 1'b0, 1'b1);
			end else if (r < 90) begin
				repeat ($urandom_range(1, 4)) emit(8'($urandom_range(0, 255)));
			end else if (r < 96) begin
				emit(cur_addr);
				emit(pick_bad_code());
			end else begin
				// A lone address: whatever follows is read as the function code.
				emit(cur_addr);
			end
		end
	endtask

	// The receiver switches between random stall patterns, and on request holds off
	// completely for a long stretch so the core fills up and stalls its input.
	initial begin : receiver
		rx_mode_t mode;
		int       left;
		int       period;
		int       tick;
		mode   = RX_FREE;
		left   = 0;
		period = 2;
		tick   = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_req = 1'b0;
				holds++;
			end else begin
				if (left == 0) begin
					mode   = rx_mode_t'($urandom_range(0, 3));
					left   = $urandom_range(50, 300);
					period = $urandom_range(2, 5);
				end
				left--;
				tick++;
				case (mode)
					RX_FREE:   m_tready <= 1'b1;
					RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= ((tick % period) == 0);
				endcase
			end
		end
	end

	// Watchdog on a plain cycle count.
	initial begin : watchdog
		while (cycles < LimitCycles) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run did not finish within %0d cycles", LimitCycles);
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		burst_left = $urandom_range(1, 40);

		// Directed part, still on the reset station address of zero: discarded bytes 0x55 and
		// 0xFF, every supported code, a rejected code that equals the address, a CRC mismatch
		// and the shortest counted frames.
		emit(8'h55);
		emit(8'hFF);
		send_frame(FC_WRITE_SINGLE, 0, 1'b0, 1'b0);
		emit(cur_addr);
		emit(8'h00);
		send_frame(FC_READ_HOLDING, 0, 1'b0, 1'b0);
		send_frame(FC_WRITE_MULTIPLE, 0, 1'b1, 1'b0);
		send_frame(FC_READ_INPUT, 0, 1'b0, 1'b0);

		// Random part across several station addresses, the extremes among them and
		// one that equals a valid function code.
		write_station(8'hFF);
		run_phase();
		write_station(8'($urandom_range(0, 255)));
		hold_req = 1'b1;
		run_phase();
		write_station(FC_READ_HOLDING);
		run_phase();
		write_station(8'($urandom_range(0, 255)));
		hold_req = 1'b1;
		run_phase();
		write_station(8'h00);
		run_phase();
		write_station(8'($urandom_range(0, 255)));
		run_phase();

		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d bytes under %0d station address writes, with %0d long output holds.",
			sent, addr_writes, holds);
		$display("Echoes checked: %0d good frames, %0d CRC mismatches, %0d discarded bytes.",
			good_frames, crc_errors, discards);
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
